### rtl/lli_pkg.sv
// Shared types and constants for the LUT linear interpolator.
// Used by lli_ctrl, lli_datapath and lut_linear_interpolator_top.
package lli_pkg;

  localparam int TableDepth = 256;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int EntryW     = 16;
  localparam int LastW      = 8;
  localparam int SampleW    = 24;
  localparam int ResultW    = 32;
  localparam int InDataW    = 48;
  localparam int PosW       = 32;  // x * last index, Q.16
  localparam int FracW      = PosW + 1;
  localparam int DiffW      = EntryW + 1;
  localparam int ProdW      = FracW + DiffW;
  localparam int AccW       = ProdW + 1;
  localparam int RndW       = AccW - 16;  // rounded sum before clipping

  typedef enum logic {
    OpWrite  = 1'b0,
    OpSample = 1'b1
  } lli_op_e;

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StAddr = 7'b0000010,
    StRdLo = 7'b0000100,
    StRdHi = 7'b0001000,
    StDiff = 7'b0010000,
    StMul  = 7'b0100000,
    StSum  = 7'b1000000
  } lli_state_e;

  // controller -> datapath
  typedef struct packed {
    logic wr_en;       // store a table entry from the input beat
    logic cap_pos;     // register x * last index
    logic cap_addr;    // register clamped indices and fraction
    logic rd_hi;       // table read address selects the upper index
    logic cap_lo;      // register lower entry
    logic cap_diff;    // register hi - lo
    logic cap_prod;    // register frac * (hi - lo)
    logic load_out;    // round, saturate, load output register
  } lli_cmd_t;

endpackage

### rtl/lli_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lli_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lli_ctrl.sv
// Sequencing state machine and output-valid flag for the interpolator.
// Depends on lli_pkg.
module lli_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lli_pkg::lli_cmd_t cmd_o
);

  lli_pkg::lli_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                out_free;

  assign in_ready_o  = (state_q == lli_pkg::StIdle);
  assign accept      = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      lli_pkg::StIdle: begin
        if (accept) begin
          if (in_op_i == lli_pkg::OpSample) begin
            cmd_o.cap_pos = 1'b1;
            state_d       = lli_pkg::StAddr;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      lli_pkg::StAddr: begin
        cmd_o.cap_addr = 1'b1;
        state_d        = lli_pkg::StRdLo;
      end
      lli_pkg::StRdLo: begin
        state_d = lli_pkg::StRdHi;
      end
      lli_pkg::StRdHi: begin
        cmd_o.rd_hi  = 1'b1;
        cmd_o.cap_lo = 1'b1;
        state_d      = lli_pkg::StDiff;
      end
      lli_pkg::StDiff: begin
        cmd_o.cap_diff = 1'b1;
        state_d        = lli_pkg::StMul;
      end
      lli_pkg::StMul: begin
        cmd_o.cap_prod = 1'b1;
        state_d        = lli_pkg::StSum;
      end
      lli_pkg::StSum: begin
        // hold until the output register can take the new beat
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = lli_pkg::StIdle;
        end
      end
      default: begin
        state_d = lli_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lli_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/lli_datapath.sv
// Interpolator datapath: last-index register, table RAM, index clamp,
// multiply, rounding and saturation, output register.
// Depends on lli_pkg and lli_ram.
module lli_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lli_pkg::lli_cmd_t                   cmd_i,
  input  logic                                cfg_we_i,
  input  logic [lli_pkg::LastW-1:0]           cfg_data_i,
  input  logic [7:0]                          entry_index_i,
  input  logic signed [lli_pkg::EntryW-1:0]   entry_value_i,
  input  logic signed [lli_pkg::SampleW-1:0]  sample_i,
  output logic signed [lli_pkg::ResultW-1:0]  result_o,
  output logic                                saturated_o
);

  logic [lli_pkg::LastW-1:0]              last_index_q;
  logic [lli_pkg::LastW-1:0]              last_eff;
  logic signed [lli_pkg::PosW-1:0]        pos_q;
  logic signed [15:0]                     i0_raw;
  logic [lli_pkg::LastW-1:0]              i0_clamp, i1_calc;
  logic [lli_pkg::AddrW-1:0]              i0_q, i1_q;
  logic signed [lli_pkg::FracW-1:0]       frac_d, frac_q;
  logic signed [lli_pkg::EntryW-1:0]      rdata, lo_q;
  logic signed [lli_pkg::DiffW-1:0]       diff_q;
  logic signed [lli_pkg::ProdW-1:0]       prod_q;
  logic signed [lli_pkg::AccW-1:0]        acc;
  logic signed [lli_pkg::RndW-1:0]        rnd;
  logic                                   sat;
  logic signed [lli_pkg::ResultW-1:0]     res_d, result_q;
  logic                                   saturated_q;
  logic                                   wr_in_range;
  logic [lli_pkg::AddrW-1:0]              raddr;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_index_q <= '1;
    end else if (cfg_we_i) begin
      last_index_q <= cfg_data_i;
    end
  end

  // effective last index never points past the table
  assign last_eff = (32'(last_index_q) > lli_pkg::TableDepth - 1)
                  ? lli_pkg::LastW'(lli_pkg::TableDepth - 1) : last_index_q;

  assign wr_in_range = 32'(entry_index_i) < lli_pkg::TableDepth;
  assign raddr       = cmd_i.rd_hi ? i1_q : i0_q;

  lli_ram #(
    .Width (lli_pkg::EntryW),
    .Depth (lli_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en & wr_in_range),
    .waddr_i (lli_pkg::AddrW'(entry_index_i)),
    .wdata_i (entry_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // floor of pos is its upper half; clamp to 0..L
  assign i0_raw = pos_q[lli_pkg::PosW-1:16];
  always_comb begin
    if (i0_raw < 0) begin
      i0_clamp = '0;
    end else if (i0_raw > $signed({8'b0, last_eff})) begin
      i0_clamp = last_eff;
    end else begin
      i0_clamp = i0_raw[lli_pkg::LastW-1:0];
    end
    i1_calc = (i0_clamp < last_eff) ? i0_clamp + 1'b1 : last_eff;
  end

  assign frac_d = lli_pkg::FracW'(pos_q) - lli_pkg::FracW'({i0_clamp, 16'h0000});

  // round half up, then clip to 32 bits
  assign acc = lli_pkg::AccW'($signed({lo_q, 16'h0000}))
             + lli_pkg::AccW'(prod_q)
             + lli_pkg::AccW'(32768);
  assign rnd = acc[lli_pkg::AccW-1:16];
  assign sat = (rnd[lli_pkg::RndW-1:lli_pkg::ResultW-1] != '0)
             && (rnd[lli_pkg::RndW-1:lli_pkg::ResultW-1] != '1);
  assign res_d = !sat ? rnd[lli_pkg::ResultW-1:0]
               : (rnd[lli_pkg::RndW-1] ? {1'b1, {(lli_pkg::ResultW-1){1'b0}}}
                                       : {1'b0, {(lli_pkg::ResultW-1){1'b1}}});

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_pos) begin
      pos_q <= lli_pkg::PosW'(sample_i) * lli_pkg::PosW'($signed({1'b0, last_eff}));
    end
    if (cmd_i.cap_addr) begin
      i0_q   <= lli_pkg::AddrW'(i0_clamp);
      i1_q   <= lli_pkg::AddrW'(i1_calc);
      frac_q <= frac_d;
    end
    if (cmd_i.cap_lo) begin
      lo_q <= rdata;
    end
    if (cmd_i.cap_diff) begin
      diff_q <= lli_pkg::DiffW'(rdata) - lli_pkg::DiffW'(lo_q);
    end
    if (cmd_i.cap_prod) begin
      prod_q <= lli_pkg::ProdW'(frac_q) * lli_pkg::ProdW'(diff_q);
    end
    if (cmd_i.load_out) begin
      result_q    <= res_d;
      saturated_q <= sat;
    end
  end

  assign result_o    = result_q;
  assign saturated_o = saturated_q;

endmodule

### rtl/lut_linear_interpolator_top.sv
// Top level of the 1-D LUT linear interpolator.
// Depends on lli_pkg, lli_ctrl, lli_datapath (and lli_ram below it).
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: index, value, sample; tuser: opcode
//  m_axis    out  m_axis_tvalid/tready       tdata: result; tuser: saturated
//  cfg       in   cfg_valid_i/cfg_ready_o    cfg_data_i: last_index
//
// A table write beat leaves the input ready. A sample beat steps through StAddr, StRdLo,
// StRdHi, StDiff, StMul and StSum, set by the two reads of the single-read-port table
// RAM and the registered multiply steps. One sample is in flight at a time.
// The output register holds a finished result while the next beat is taken.
// Reset restores last_index to 255; table contents are undefined until written.
// A stalled output holds the next sample in its final step.
module lut_linear_interpolator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // [7:0] entry_index, [23:8] entry_value, [47:24] sample
  input  logic        s_axis_tuser,  // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] result
  output logic        m_axis_tuser,  // [0] saturated
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  lli_pkg::lli_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  lli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  lli_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .entry_index_i (s_axis_tdata[7:0]),
    .entry_value_i ($signed(s_axis_tdata[23:8])),
    .sample_i      ($signed(s_axis_tdata[47:24])),
    .result_o      (m_axis_tdata),
    .saturated_o   (m_axis_tuser)
  );

  // a sample beat blocks the input while it is worked on
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("input ready right after a sample beat");

  // table writes never block the input
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
    else $error("input blocked after a table write");

  // a clipped result sits at one of the 32-bit limits
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata == 32'h7fff_ffff) || (m_axis_tdata == 32'h8000_0000))
    else $error("saturated flag with unclipped result");

endmodule

### sim/tb_lut_linear_interpolator_top.sv
// Self-checking testbench for lut_linear_interpolator_top: table loads, samples, last-index changes.
// Needs lli_pkg and the RTL below the top level. A scoreboard class predicts each result.
module tb_lut_linear_interpolator_top;

  localparam int WdogLimit = 2000;   // cycles with no accepted beat on any channel
  localparam int SettleCyc = 12;     // extra wait after the last expected result arrives
  localparam int HoldCyc   = 300;
  localparam longint ResMax = (64'sd1 <<< 31) - 1;
  localparam longint ResMin = -(64'sd1 <<< 31);

  class interp_scoreboard;
    typedef struct {
      logic [31:0] result;
      logic        saturated;
    } interp_res_t;

    interp_res_t        expected_q[$];
    logic signed [15:0] lut [lli_pkg::TableDepth];
    logic [7:0]         last_idx = 8'd255;
    int                 mismatches = 0;
    int                 checked = 0;
    int                 writes = 0;
    int                 samples = 0;

    function void set_last_index(logic [7:0] v);
      last_idx = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(lli_pkg::lli_op_e op, logic [7:0] idx, logic signed [15:0] val,
                             logic signed [23:0] x);
      longint      span, pos, i0, i1, frac, lo, hi, acc, r;
      interp_res_t e;
      if (op == lli_pkg::OpWrite) begin
        lut[idx] = val;
        writes++;
        return;
      end
      samples++;
      span = last_idx;
      if (span > lli_pkg::TableDepth - 1) span = lli_pkg::TableDepth - 1;
      pos = longint'(x) * span;
      i0  = pos >>> 16;
      if (i0 < 0) i0 = 0;
      if (i0 > span) i0 = span;
      i1 = (i0 + 1 < span) ? i0 + 1 : span;
      // fraction leaves [0,1) below the table start: extrapolates along first segment
      frac = pos - i0 * 65536;
      lo   = lut[int'(i0)];
      hi   = lut[int'(i1)];
      acc  = lo * 65536 + frac * (hi - lo);
      r    = (acc + 32768) >>> 16;  // round half up
      e.saturated = 1'b0;
      if (r > ResMax) begin
        r = ResMax;
        e.saturated = 1'b1;
      end else if (r < ResMin) begin
        r = ResMin;
        e.saturated = 1'b1;
      end
      e.result = r[31:0];
      expected_q.push_back(e);
    endfunction

    function void check_result(logic [31:0] res, logic sat);
      interp_res_t e;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat %0d arrived with nothing expected: result %0d saturated %0b",
                   checked, $signed(res), sat);
        return;
      end
      e = expected_q.pop_front();
      if (res !== e.result || sat !== e.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat %0d: result exp %0d got %0d, saturated exp %0b got %0b",
                   checked, $signed(e.result), $signed(res), e.saturated, sat);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // [7:0] entry_index, [23:8] entry_value, [47:24] sample
  logic        s_axis_tuser;   // [0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] result
  logic        m_axis_tuser;   // [0] saturated
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;

  interp_scoreboard sb = new();

  bit         loaded [lli_pkg::TableDepth];
  logic [7:0] spans [6] = '{8'd255, 8'd2, 8'd128, 8'd17, 8'd254, 8'd1};
  int         burst_left = 0;
  int         results_seen = 0;
  int         hold_left = 0;
  int         rx_tick = 0;
  int         idle_cycles = 0;
  int         settings_used = 0;

  lut_linear_interpolator_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // one input beat; bursts of random length separated by random gaps
  task automatic send_beat(input lli_pkg::lli_op_e op, input logic [7:0] idx,
                           input logic [15:0] val, input logic [23:0] x);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = int'($urandom_range(1, 24));
    end
    burst_left--;
    s_axis_tdata  <= {x, val, idx};
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, idx, val, x);
  endtask

  task automatic load_entry(input logic [7:0] idx, input logic [15:0] val);
    loaded[idx] = 1'b1;
    send_beat(lli_pkg::OpWrite, idx, val, 24'($urandom));
  endtask

  task automatic interp_sample(input logic [23:0] x);
    send_beat(lli_pkg::OpSample, 8'($urandom), 16'($urandom), x);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_last_index(input logic [7:0] v);
    wait_drained();
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_last_index(v);
    settings_used++;
  endtask

  // random phase: entries 0..span are loaded before any sample may read them
  task automatic run_phase(input logic [7:0] span, input int n_samples, input bit mid_pause);
    int          sent;
    int          gap_idx;
    logic [23:0] x;
    write_last_index(span);
    sent = 0;
    while (sent < n_samples) begin
      gap_idx = -1;
      for (int k = int'(span); k >= 0; k--)
        if (!loaded[k]) gap_idx = k;
      if (gap_idx >= 0) begin
        load_entry(gap_idx[7:0], 16'($urandom));
      end else if ($urandom_range(0, 9) < 3) begin
        load_entry(8'($urandom_range(0, 255)), 16'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0:             x = $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
          1, 2, 3, 4, 5: x = 24'($urandom_range(0, 65536));
          6, 7:          x = 24'($urandom_range(0, 262144) - 131072);
          default:       x = 24'($urandom);
        endcase
        interp_sample(x);
        sent++;
        if (mid_pause && sent == n_samples / 2) wait_drained();
      end
    end
  endtask

  // receiver: own ready pattern, plus long hold-offs that back the core up into its input
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tuser);
        results_seen++;
        if (results_seen == 45 || results_seen == 100) hold_left = HoldCyc;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        rx_tick++;
        case ((rx_tick / 150) % 3)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= (rx_tick % 7) < 3;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WdogLimit) begin
        $display("watchdog: no beat accepted for %0d cycles", WdogLimit);
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset last index: small x only touches entries 0 and 1
    load_entry(8'd0, 16'd100);
    load_entry(8'd1, -16'sd200);
    interp_sample(24'd0);
    interp_sample(24'd128);

    // two-entry table: rounding ties both signs, extreme entries and extreme x
    write_last_index(8'd1);
    load_entry(8'd0, 16'd0);
    load_entry(8'd1, 16'd1);
    interp_sample(24'd32768);
    load_entry(8'd1, 16'hFFFF);
    interp_sample(24'd32768);
    load_entry(8'd0, 16'h7FFF);
    load_entry(8'd1, 16'h8000);
    interp_sample(24'd0);
    interp_sample(24'd65536);
    interp_sample(24'd65535);
    interp_sample(24'hFFFFFF);
    interp_sample(24'h7FFFFF);
    interp_sample(24'h800000);
    interp_sample(24'd32768);

    // last index zero: everything reads entry 0
    write_last_index(8'd0);
    interp_sample(24'h7FFFFF);
    interp_sample(24'h800000);
    interp_sample(24'd12345);
    load_entry(8'd0, 16'h8000);
    interp_sample(24'd0);

    foreach (spans[p])
      run_phase(spans[p], (p == 0) ? 25 : 20, p == 3);

    wait_drained();
    $display("run covered %0d table writes and %0d samples over %0d last-index settings",
             sb.writes, sb.samples, settings_used);
    $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
